### hw/rtl/mpfb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the monochrome page framebuffer blitter.
package mpfb_pkg;

   // Operation codes
   localparam logic [1:0] OP_BLIT  = 2'd0;
   localparam logic [1:0] OP_POINT = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Register file layout
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLIT_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLIT_PAGES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRAW_MODE  = 3'd4;

   // Widest bitmap row; zero or larger widths fall back to this
   localparam logic [7:0] BLIT_WIDTH_MAX = 8'd128;
   localparam logic [7:0] BLIT_WIDTH_RST = 8'd128;
   localparam logic [3:0] BLIT_PAGES_RST = 4'd8;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] bitmap_byte;
      logic       first_of_image;
      logic [6:0] point_x;
      logic [5:0] point_y;
      logic       point_on;
      logic [2:0] read_page;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } rsp_type;

   typedef struct packed {
      logic [6:0] origin_x;
      logic [5:0] origin_y;
      logic [7:0] blit_width;
      logic [3:0] blit_pages;
      logic       draw_mode;
   } cfg_type;

   // Access plan for one item: up to two read-modify-writes of frame bytes
   typedef struct packed {
      logic       en0;
      logic       en1;
      logic       is_read;
      logic       clip;
      logic [7:0] mask0;
      logic [7:0] data0;
      logic [7:0] mask1;
      logic [7:0] data1;
   } plan_type;

endpackage

### hw/rtl/mpfb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module mpfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/mpfb_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the blitter.
module mpfb_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mpfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpfb_pkg::CSR_DATA_W-1:0] csr_data,
   output mpfb_pkg::cfg_type               cfg
);
   import mpfb_pkg::*;

   cfg_type cfg_ff;

   // Writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.blit_width <= BLIT_WIDTH_RST;
         cfg_ff.blit_pages <= BLIT_PAGES_RST;
         cfg_ff.draw_mode  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ORIGIN_X:   cfg_ff.origin_x   <= csr_data[6:0];
            REG_ORIGIN_Y:   cfg_ff.origin_y   <= csr_data[5:0];
            REG_BLIT_WIDTH: cfg_ff.blit_width <= csr_data[7:0];
            REG_BLIT_PAGES: cfg_ff.blit_pages <= csr_data[3:0];
            REG_DRAW_MODE:  cfg_ff.draw_mode  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/mpfb_cursor.sv
`timescale 1ns / 1ps
// Blit cursor and per-item access planner: addresses, masks and clip flags.
module mpfb_cursor #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8,
   parameter int ADDR_W  = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mpfb_pkg::req_type   req,
   input  mpfb_pkg::cfg_type   cfg,
   output mpfb_pkg::plan_type  plan,
   output logic [ADDR_W-1:0]   addr0,
   output logic [ADDR_W-1:0]   addr1
);
   import mpfb_pkg::*;

   localparam logic [8:0]  COLS_LIM  = 9'(COLUMNS);
   localparam logic [5:0]  PAGES_LIM = 6'(PAGES);
   localparam logic [15:0] PAGES_MUL = 16'(PAGES);

   logic [6:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic [3:0]  cnt_ff, cnt_in;
   plan_type    plan_ff, plan_in;
   logic [ADDR_W-1:0] addr0_ff, addr1_ff;

   logic [6:0]  eff_col;
   logic [7:0]  eff_row;
   logic [3:0]  eff_cnt;
   logic [7:0]  width_eff;
   logic [7:0]  col_inc;
   logic [7:0]  blit_x;
   logic [2:0]  shift;
   logic [5:0]  blit_p0;
   logic [5:0]  blit_p1;
   logic [7:0]  val;
   logic        blit_active;
   logic        blit_x_ok;
   logic        pt_ok;
   logic        rd_ok;
   logic [7:0]  pt_mask;
   logic [7:0]  sel_x;
   logic [5:0]  sel_p0;
   logic [5:0]  sel_p1;
   logic [15:0] base;
   logic [15:0] lin0;
   logic [15:0] lin1;

   // Cursor as seen by this beat, after an optional restart
   always_comb begin
      if (req.first_of_image) begin
         eff_col = '0;
         eff_row = {2'b00, cfg.origin_y};
         eff_cnt = '0;
      end else begin
         eff_col = col_ff;
         eff_row = row_ff;
         eff_cnt = cnt_ff;
      end
   end

   assign width_eff   = (cfg.blit_width == 8'd0 || cfg.blit_width > BLIT_WIDTH_MAX) ?
                        BLIT_WIDTH_MAX : cfg.blit_width;
   assign col_inc     = {1'b0, eff_col} + 8'd1;
   assign blit_x      = {1'b0, cfg.origin_x} + {1'b0, eff_col};
   assign shift       = eff_row[2:0];
   assign blit_p0     = {1'b0, eff_row[7:3]};
   assign blit_p1     = blit_p0 + 6'd1;
   assign val         = cfg.draw_mode ? req.bitmap_byte : ~req.bitmap_byte;
   assign blit_active = eff_cnt < cfg.blit_pages;
   assign blit_x_ok   = {1'b0, blit_x} < COLS_LIM;
   assign pt_ok       = ({2'b00, req.point_x} < COLS_LIM) &&
                        ({3'b000, req.point_y[5:3]} < PAGES_LIM);
   assign rd_ok       = ({2'b00, req.point_x} < COLS_LIM) &&
                        ({3'b000, req.read_page} < PAGES_LIM);
   assign pt_mask     = 8'h01 << req.point_y[2:0];

   // Plan the frame accesses for this beat
   always_comb begin
      plan_in = '0;
      sel_x   = {1'b0, req.point_x};
      sel_p0  = {3'b000, req.read_page};
      case (req.operation)
         OP_BLIT: begin
            sel_x  = blit_x;
            sel_p0 = blit_p0;
            if (!blit_active) begin
               plan_in.clip = 1'b1;
            end else begin
               plan_in.en0   = blit_x_ok && (blit_p0 < PAGES_LIM);
               plan_in.en1   = blit_x_ok && (shift != 3'd0) && (blit_p1 < PAGES_LIM);
               plan_in.clip  = !blit_x_ok || !(blit_p0 < PAGES_LIM) ||
                               ((shift != 3'd0) && !(blit_p1 < PAGES_LIM));
               plan_in.mask0 = 8'hFF << shift;
               plan_in.data0 = val << shift;
               plan_in.mask1 = 8'hFF >> (4'd8 - {1'b0, shift});
               plan_in.data1 = val >> (4'd8 - {1'b0, shift});
            end
         end
         OP_POINT: begin
            sel_p0        = {3'b000, req.point_y[5:3]};
            plan_in.en0   = pt_ok;
            plan_in.clip  = !pt_ok;
            plan_in.mask0 = pt_mask;
            plan_in.data0 = req.point_on ? pt_mask : 8'h00;
         end
         OP_READ: begin
            plan_in.is_read = 1'b1;
            plan_in.en0     = rd_ok;
            plan_in.clip    = !rd_ok;
         end
         default: ;
      endcase
   end

   // Linear address: column * PAGES + page
   assign base   = {8'h00, sel_x} * PAGES_MUL;
   assign sel_p1 = sel_p0 + 6'd1;
   assign lin0   = base + {10'h000, sel_p0};
   assign lin1   = base + {10'h000, sel_p1};

   // Cursor advance after a blit beat that lands inside the image
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (req.operation == OP_BLIT) begin
         col_in = eff_col;
         row_in = eff_row;
         cnt_in = eff_cnt;
         if (blit_active) begin
            if (col_inc >= width_eff) begin
               col_in = '0;
               row_in = eff_row + 8'd8;
               cnt_in = eff_cnt + 4'd1;
            end else begin
               col_in = col_inc[6:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cnt_ff  <= '0;
         plan_ff <= '0;
      end else if (load) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cnt_ff  <= cnt_in;
         plan_ff <= plan_in;
      end
   end

   // Addresses are payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         addr0_ff <= lin0[ADDR_W-1:0];
         addr1_ff <= lin1[ADDR_W-1:0];
      end
   end

   assign plan  = plan_ff;
   assign addr0 = addr0_ff;
   assign addr1 = addr1_ff;

endmodule

### hw/rtl/mono_page_framebuffer_blitter.sv
`timescale 1ns / 1ps
// Top level of the monochrome page framebuffer blitter.
//
// Usage:
//   Items enter on the command channel: a beat is taken when start is high
//   and busy is low. Each item gives exactly one result beat, shown on
//   rsp_item for one cycle with rsp_valid high; the receiver cannot stall it.
//   Configuration writes go over the csr_ channel (csr_ready is always high)
//   and belong in idle periods only.
//   Sequence: the planner registers addresses at the accept edge, then the
//   frame RAM is read (ST_RD0) and the merged byte is written back (ST_MOD0).
//   A read, point or page-aligned blit gives its result after ST_MOD0; busy
//   stays high until then, so no new item is taken before. A blit byte
//   that straddles two pages needs a second write-back (ST_MOD1) before its
//   result. Clear all walks every frame byte at one write a cycle and gives
//   its result after the last byte. After reset the same sweep zeroes the
//   frame (busy high, no result beat); configuration writes are still taken
//   meanwhile.
module mono_page_framebuffer_blitter #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mpfb_pkg::req_type               req_item,
   output logic                            rsp_valid,
   output mpfb_pkg::rsp_type               rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mpfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpfb_pkg::CSR_DATA_W-1:0] csr_data
);
   import mpfb_pkg::*;

   localparam int DEPTH  = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RD0,
      ST_MOD0,
      ST_MOD1
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              clr_rsp_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   cfg_type           cfg;
   plan_type          plan;
   logic [ADDR_W-1:0] addr0;
   logic [ADDR_W-1:0] addr1;
   logic              load;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   assign busy = (state_ff != ST_IDLE);
   assign load = start && !busy;

   mpfb_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mpfb_cursor #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES),
      .ADDR_W  (ADDR_W)
   ) u_cursor (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .req   (req_item),
      .cfg   (cfg),
      .plan  (plan),
      .addr0 (addr0),
      .addr1 (addr1)
   );

   mpfb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Frame RAM port steering: clear sweep, or read-modify-write of one or two bytes
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr0;
      ram_wdata = (ram_rdata & ~plan.mask0) | plan.data0;
      ram_raddr = addr0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = 8'h00;
         end
         ST_MOD0: begin
            ram_we    = plan.en0 && !plan.is_read;
            ram_raddr = addr1;
         end
         ST_MOD1: begin
            ram_we    = plan.en1;
            ram_waddr = addr1;
            ram_wdata = (ram_rdata & ~plan.mask1) | plan.data1;
         end
         default: ;
      endcase
   end

   // Sequencer with the result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (req_item.operation == OP_CLEAR) begin
                     state_ff   <= ST_CLEAR;
                     clr_cnt_ff <= '0;
                     clr_rsp_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_RD0;
                  end
               end
            end
            ST_CLEAR: begin
               if (clr_cnt_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
                  if (clr_rsp_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '0;
                  end
               end else begin
                  clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
               end
            end
            ST_RD0: begin
               state_ff <= ST_MOD0;
            end
            ST_MOD0: begin
               rsp_ff.read_data <= (plan.is_read && plan.en0) ? ram_rdata : 8'h00;
               rsp_ff.clipped   <= plan.clip;
               if (plan.en1) begin
                  state_ff <= ST_MOD1;
               end else begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_MOD1: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   // An accepted beat always takes the block out of idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   // Never two result beats back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Only a frame read returns non-zero data
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !plan.is_read |-> rsp_item.read_data == 8'h00)
      else $error("non-read beat returned data");

   // The read cycle never writes the frame
   a_rd_nowrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD0 |-> !ram_we)
      else $error("frame write during read cycle");

   // A second page is only touched together with the first
   a_plan_pair: assert property (@(posedge clock) disable iff (reset)
      plan.en1 |-> plan.en0)
      else $error("second page planned without first");
`endif

endmodule
